### design/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  localparam int CELL_W = 16;
  localparam int CFG_AW = 3;

  // register word index taken from paddr[2]
  localparam logic CFG_IDX_ATTR = 1'b0;

  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic [15:0] cell_data;
    logic        did_scroll;
  } out_item_t;

endpackage

`default_nettype wire

### design/tccw_ram.sv
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/text_console_char_writer.sv
// Text console engine: a COLUMNS x ROWS store of 16-bit cells (attribute in the high byte,
// character in the low byte) in one synchronous RAM, plus a cursor. Put, read and no-op
// commands pass through an accept state and one execute state with a RAM access; a put
// that runs past the last row then copies each row one row up and blanks the last row,
// one cell per cycle through the RAM's single read and single write port, and then loads
// the result. Clear writes blanks to every cell and then loads the result. After reset
// the RAM is swept to blanks before in_ready rises; the attribute register can be written
// meanwhile.
// A finished result sits in the output register while the next item is taken, but an item
// whose result finds that register still full waits until it is taken.
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tccw_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tccw_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tccw_pkg::out_item_t              out_data,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [tccw_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNW   = $clog2(CELLS + 1);
  localparam int CBW   = $clog2(COLUMNS);
  localparam int SW    = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RBW   = $clog2(ROWS);
  localparam int RSW   = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TAB_WIDTH);
  localparam int W     = tccw_pkg::CELL_W;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNW-1:0]     cnt_r, cnt_nxt;
  logic [CBW-1:0]     col_r, col_nxt;
  logic [RBW-1:0]     row_r, row_nxt;
  logic [PW-1:0]      phase_r, phase_nxt;
  logic [7:0]         attr_r;
  tccw_pkg::cmd_t     cmd_r;
  logic [7:0]         char_r;
  logic               rd_ok_r;
  logic [W-1:0]       res_data_r, res_data_nxt;
  logic               res_scroll_r, res_scroll_nxt;
  logic               out_valid_r;
  tccw_pkg::out_item_t out_data_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [W-1:0]       ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [W-1:0]       ram_rdata;

  logic               out_free;
  logic               out_ld;
  logic               cfg_wr;
  logic [W-1:0]       blank;

  tccw_ram #(
    .WIDTH (W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign blank     = {attr_r, tccw_pkg::CH_SPACE};

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == tccw_pkg::CFG_IDX_ATTR);
  assign cfg_prdata = (cfg_paddr[2] == tccw_pkg::CFG_IDX_ATTR) ? {24'b0, attr_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccw_pkg::ATTR_RESET;
    end else if (cfg_wr) begin
      attr_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    logic [SW-1:0]  col_s;
    logic [RSW-1:0] row_s;
    logic [PW-1:0]  phase_s;
    logic           fin;

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    phase_nxt      = phase_r;
    res_data_nxt   = res_data_r;
    res_scroll_nxt = res_scroll_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = AW'(in_data.cell_index);
    out_ld         = 1'b0;
    fin            = 1'b0;
    col_s          = SW'(col_r);
    row_s          = RSW'(row_r);
    phase_s        = phase_r;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_r);
        ram_wdata = {tccw_pkg::ATTR_RESET, tccw_pkg::CH_SPACE};
        if (cnt_r == CNW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_data_nxt   = '0;
        res_scroll_nxt = 1'b0;
        case (cmd_r)
          tccw_pkg::CMD_PUT: begin
            case (char_r)
              tccw_pkg::CH_BS: begin
                if (col_r != '0) begin
                  col_s   = col_s - 1'b1;
                  phase_s = (phase_r == '0) ? PW'(TAB_WIDTH - 1) : phase_r - 1'b1;
                end
              end
              tccw_pkg::CH_TAB: begin
                col_s   = SW'(col_r) + SW'(TAB_WIDTH) - SW'(phase_r);
                phase_s = '0;
              end
              tccw_pkg::CH_CR: begin
                col_s   = '0;
                phase_s = '0;
              end
              tccw_pkg::CH_LF: begin
                col_s   = '0;
                row_s   = row_s + 1'b1;
                phase_s = '0;
              end
              default: begin
                if (char_r inside {[tccw_pkg::CH_SPACE:tccw_pkg::CH_LAST]}) begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(32'(row_r) * COLUMNS + 32'(col_r));
                  ram_wdata = {attr_r, char_r};
                  col_s     = col_s + 1'b1;
                  phase_s   = (phase_r == PW'(TAB_WIDTH - 1)) ? '0 : phase_r + 1'b1;
                end
              end
            endcase
            // wrap past the last column
            if (col_s >= SW'(COLUMNS)) begin
              col_s   = '0;
              row_s   = row_s + 1'b1;
              phase_s = '0;
            end
            col_nxt   = CBW'(col_s);
            phase_nxt = phase_s;
            if (row_s >= RSW'(ROWS)) begin
              row_nxt        = RBW'(ROWS - 1);
              res_scroll_nxt = 1'b1;
              cnt_nxt        = '0;
              state_nxt      = S_SCROLL;
            end else begin
              row_nxt = RBW'(row_s);
              fin     = 1'b1;
            end
          end
          tccw_pkg::CMD_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            phase_nxt = '0;
            cnt_nxt   = '0;
            state_nxt = S_FILL;
          end
          tccw_pkg::CMD_READ: begin
            res_data_nxt = rd_ok_r ? ram_rdata : '0;
            fin          = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          if (out_free) begin
            out_ld    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCROLL: begin
        // read one row ahead, write the word read last cycle one row up
        ram_raddr = (cnt_r < CNW'(CELLS - COLUMNS)) ? AW'(32'(cnt_r) + COLUMNS) : '0;
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cnt_r - 1'b1);
          ram_wdata = (cnt_r <= CNW'(CELLS - COLUMNS)) ? ram_rdata : blank;
        end
        if (cnt_r == CNW'(CELLS)) begin
          cnt_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_r);
        ram_wdata = blank;
        if (cnt_r == CNW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cnt_r        <= '0;
      col_r        <= '0;
      row_r        <= '0;
      phase_r      <= '0;
      res_data_r   <= '0;
      res_scroll_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      phase_r      <= phase_nxt;
      res_data_r   <= res_data_nxt;
      res_scroll_r <= res_scroll_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_data.command;
      char_r  <= in_data.char_code;
      rd_ok_r <= (32'(in_data.cell_index) < CELLS);
    end
    if (out_ld) begin
      out_data_r.cursor_col    <= 7'(col_nxt);
      out_data_r.cursor_row    <= 5'(row_nxt);
      out_data_r.cursor_linear <= 11'(32'(row_nxt) * COLUMNS + 32'(col_nxt));
      out_data_r.cell_data     <= res_data_nxt;
      out_data_r.did_scroll    <= res_scroll_nxt;
    end
  end

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transfer accepted while previous item still executing");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INIT) |-> (32'(row_r) < ROWS && 32'(col_r) < COLUMNS))
    else $error("cursor outside the screen");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.did_scroll) |-> (out_data_r.cursor_row == 5'(ROWS - 1)))
    else $error("scroll result not on last row");

endmodule

`default_nettype wire
